/* rtl/core/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while rst is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/qrm_pkg.sv */
`default_nettype none
package qrm_pkg;

   localparam int NUM_LANES = 9;
   localparam int DIV_STEPS = 16;
   localparam int N_W       = 33;
   localparam int R_W       = 34;
   localparam int NUM_W     = 35;
   localparam int Q_W       = DIV_STEPS;
   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

   typedef struct packed {
      logic             neg;
      logic [R_W-1:0]   rem;
      logic [Q_W-1:0]   quo;
   } lane_type;

   typedef struct packed {
      lane_type [NUM_LANES-1:0] lane;
      logic [N_W-1:0]           den;
      logic                     zero;
   } div_type;

endpackage
`default_nettype wire

/* rtl/core/quaternion_to_rotation_matrix.sv */
// one quaternion per cycle sustained while the output is not stalled
// stages: input, products, sums, sign split, 16 restoring divider steps, round and output
// the 16 shared-denominator divider steps make up most of the pipeline
// a stage holds its item while the next one is full and cannot move on, so a stall loses nothing
// reset (synchronous) empties the pipeline; data registers are not reset
`default_nettype none
`include "assert_macros.svh"
module quaternion_to_rotation_matrix
   import qrm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_comp_w,
   input  wire logic signed [15:0] req_comp_x,
   input  wire logic signed [15:0] req_comp_y,
   input  wire logic signed [15:0] req_comp_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_c0_r0,
   output logic signed [15:0]      rsp_c0_r1,
   output logic signed [15:0]      rsp_c0_r2,
   output logic signed [15:0]      rsp_c1_r0,
   output logic signed [15:0]      rsp_c1_r1,
   output logic signed [15:0]      rsp_c1_r2,
   output logic signed [15:0]      rsp_c2_r0,
   output logic signed [15:0]      rsp_c2_r1,
   output logic signed [15:0]      rsp_c2_r2,
   output logic                    rsp_zero_input
);

   // stage valids and load enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic load1, load2, load3, load4, load_out;
   logic [DIV_STEPS-1:0] vd;
   logic [DIV_STEPS-1:0] load_d;

   // stage 1: input registers
   logic signed [15:0] w_ff, x_ff, y_ff, z_ff;

   // stage 2: products
   logic signed [31:0] ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [31:0] xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;

   // stage 3: norm and numerators
   logic [N_W-1:0]          n_ff;
   logic signed [NUM_W-1:0] num_ff [NUM_LANES];
   logic signed [NUM_W-1:0] num_in [NUM_LANES];
   logic [N_W-1:0]          n_in;
   logic                    zero3_ff;

   // stage 4 and divider chain
   div_type d4_ff;
   div_type d4_in;
   div_type dd [DIV_STEPS];

   // output stage
   logic signed [15:0] out_ff [NUM_LANES];
   logic signed [15:0] out_in [NUM_LANES];
   logic               zero_out_ff;

   // load chain from the output back to the input
   always_comb begin
      load_out = !rsp_valid_ff || !rsp_stall;
      load_d[DIV_STEPS-1] = !vd[DIV_STEPS-1] || load_out;
      for (int k = DIV_STEPS - 2; k >= 0; k--) begin
         load_d[k] = !vd[k] || load_d[k+1];
      end
      load4 = !v4_ff || load_d[0];
      load3 = !v3_ff || load4;
      load2 = !v2_ff || load3;
      load1 = !v1_ff || load2;
   end

   assign req_stall = !load1;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load1) begin
            v1_ff <= req_valid;
         end
         if (load2) begin
            v2_ff <= v1_ff;
         end
         if (load3) begin
            v3_ff <= v2_ff;
         end
         if (load4) begin
            v4_ff <= v3_ff;
         end
         if (load_out) begin
            rsp_valid_ff <= vd[DIV_STEPS-1];
         end
      end
   end

   // input capture
   always_ff @(posedge clock) begin
      if (load1) begin
         w_ff <= req_comp_w;
         x_ff <= req_comp_x;
         y_ff <= req_comp_y;
         z_ff <= req_comp_z;
      end
   end

   // products
   always_ff @(posedge clock) begin
      if (load2) begin
         ww_ff <= w_ff * w_ff;
         xx_ff <= x_ff * x_ff;
         yy_ff <= y_ff * y_ff;
         zz_ff <= z_ff * z_ff;
         xy_ff <= x_ff * y_ff;
         xz_ff <= x_ff * z_ff;
         yz_ff <= y_ff * z_ff;
         wx_ff <= w_ff * x_ff;
         wy_ff <= w_ff * y_ff;
         wz_ff <= w_ff * z_ff;
      end
   end

   // norm and numerators
   always_comb begin
      logic signed [NUM_W-1:0] eww, exx, eyy, ezz, exy, exz, eyz, ewx, ewy, ewz;
      eww = NUM_W'(ww_ff);
      exx = NUM_W'(xx_ff);
      eyy = NUM_W'(yy_ff);
      ezz = NUM_W'(zz_ff);
      exy = NUM_W'(xy_ff);
      exz = NUM_W'(xz_ff);
      eyz = NUM_W'(yz_ff);
      ewx = NUM_W'(wx_ff);
      ewy = NUM_W'(wy_ff);
      ewz = NUM_W'(wz_ff);
      n_in = N_W'(eww + exx + eyy + ezz);
      num_in[0] = eww + exx - eyy - ezz;
      num_in[1] = (exy + ewz) <<< 1;
      num_in[2] = (exz - ewy) <<< 1;
      num_in[3] = (exy - ewz) <<< 1;
      num_in[4] = eww - exx + eyy - ezz;
      num_in[5] = (eyz + ewx) <<< 1;
      num_in[6] = (exz + ewy) <<< 1;
      num_in[7] = (eyz - ewx) <<< 1;
      num_in[8] = eww - exx - eyy + ezz;
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         n_ff     <= n_in;
         num_ff   <= num_in;
         zero3_ff <= (n_in == '0);
      end
   end

   // sign and magnitude for the divider
   always_comb begin
      logic [NUM_W-1:0] mag;
      d4_in.den  = n_ff;
      d4_in.zero = zero3_ff;
      for (int i = 0; i < NUM_LANES; i++) begin
         mag = num_ff[i][NUM_W-1] ? NUM_W'(-num_ff[i]) : NUM_W'(num_ff[i]);
         d4_in.lane[i].neg = num_ff[i][NUM_W-1];
         d4_in.lane[i].rem = mag[R_W-1:0];
         d4_in.lane[i].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load4) begin
         d4_ff <= d4_in;
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      qrm_div_stage #(
         .FIRST (k == 0)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .load      (load_d[k]),
         .valid_in  ((k == 0) ? v4_ff : vd[(k == 0) ? 0 : k-1]),
         .data_in   ((k == 0) ? d4_ff : dd[(k == 0) ? 0 : k-1]),
         .valid_out (vd[k]),
         .data_out  (dd[k])
      );
   end

   // round half up on the doubled quotient, clamp, restore sign; identity matrix for a zero-norm input
   always_comb begin
      logic [Q_W:0]  t;
      logic [15:0]   q;
      for (int i = 0; i < NUM_LANES; i++) begin
         t = ({1'b0, dd[DIV_STEPS-1].lane[i].quo} + 17'd1) >> 1;
         q = t[15:0];
         if (q > 16'(ONE_Q14)) begin
            q = 16'(ONE_Q14);
         end
         out_in[i] = dd[DIV_STEPS-1].lane[i].neg ? -$signed(q) : $signed(q);
         if (dd[DIV_STEPS-1].zero) begin
            out_in[i] = (i == 0 || i == 4 || i == 8) ? ONE_Q14 : 16'sd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ff      <= out_in;
         zero_out_ff <= dd[DIV_STEPS-1].zero;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_c0_r0      = out_ff[0];
   assign rsp_c0_r1      = out_ff[1];
   assign rsp_c0_r2      = out_ff[2];
   assign rsp_c1_r0      = out_ff[3];
   assign rsp_c1_r1      = out_ff[4];
   assign rsp_c1_r2      = out_ff[5];
   assign rsp_c2_r0      = out_ff[6];
   assign rsp_c2_r1      = out_ff[7];
   assign rsp_c2_r2      = out_ff[8];
   assign rsp_zero_input = zero_out_ff;

   // checks
   `ASSERT_ALWAYS(a_empty_front_ready, clock, !v1_ff |-> !req_stall, "front stage empty but stalled")
   `ASSERT_CLK(a_zero_identity, clock, reset,
      rsp_valid && rsp_zero_input |-> rsp_c0_r0 == ONE_Q14 && rsp_c0_r1 == 16'sd0,
      "zero input without identity")
   `ASSERT_CLK(a_range, clock, reset,
      rsp_valid |-> rsp_c1_r1 <= ONE_Q14 && rsp_c1_r1 >= -ONE_Q14, "entry out of range")

endmodule
`default_nettype wire

/* rtl/core/qrm_div_stage.sv */
`default_nettype none
module qrm_div_stage
   import qrm_pkg::*;
#(
   parameter bit FIRST = 1'b0
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire logic    valid_in,
   input  wire div_type data_in,
   output logic         valid_out,
   output div_type      data_out
);

   logic    valid_ff;
   div_type data_ff;
   div_type data_in_next;

   // one restoring quotient bit per lane
   always_comb begin
      logic [R_W-1:0] part;
      logic           ge;
      data_in_next = data_in;
      for (int i = 0; i < NUM_LANES; i++) begin
         part = FIRST ? data_in.lane[i].rem : {data_in.lane[i].rem[R_W-2:0], 1'b0};
         ge   = part >= {1'b0, data_in.den};
         data_in_next.lane[i].rem = ge ? part - {1'b0, data_in.den} : part;
         data_in_next.lane[i].quo = {data_in.lane[i].quo[Q_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule
`default_nettype wire
